FILE: design/flp_pkg.sv
// ----------------------------------------------------------------------------
// flp_pkg: shared types and constants of the framebuffer line plotter
// Geometry of the graph, register addresses and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package flp_pkg;
  localparam int GRAPH_WIDTH   = 400;
  localparam int GRAPH_HEIGHT  = 240;
  localparam int WORDS_PER_ROW = 16;
  localparam int STORE_DEPTH   = GRAPH_HEIGHT * WORDS_PER_ROW;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);

  localparam logic [0:0] REG_ASPECT = 1'b0;
  localparam logic [0:0] REG_MARGIN = 1'b1;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_XDIV,
    ST_YDIV,
    ST_PIX,
    ST_RD,
    ST_WR,
    ST_RDCMD,
    ST_RDOUT
  } state_t;
endpackage
`default_nettype wire

FILE: design/flp_ram.sv
// ----------------------------------------------------------------------------
// flp_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module flp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3840
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: design/framebuffer_line_plotter.sv
// ----------------------------------------------------------------------------
// framebuffer_line_plotter: monochrome line drawing engine
// Draws clipped lines into a 1-bit framebuffer and reads back its words.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. A draw
// request (action 0) rasterizes a line with an x-sweep and then a y-sweep;
// a read request (action 1) fetches one 32-bit framebuffer word. Every
// request gives exactly one result, shown for one cycle with done high:
// read_data and was_read. The receiver cannot stall, so results never wait.
// Each pixel of a line costs one 17-step restoring division (a set-up
// step, one quotient bit per cycle and a step that places the coordinate)
// plus a read-modify-write of the frame memory; the serial divider and
// the single-port frame memory set the cost of a pixel. After reset the
// block sweeps all 3840 words of the frame memory to zero, one word a
// cycle, and holds busy high meanwhile; register writes over the APB
// port are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module framebuffer_line_plotter
  import flp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [8:0]  start_x,
  input  wire logic [7:0]  start_y,
  input  wire logic [8:0]  end_x,
  input  wire logic [7:0]  end_y,
  input  wire logic        set_pixels,
  input  wire logic [11:0] read_address,
  output logic             done,
  output logic [31:0]      read_data,
  output logic             was_read,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // Configuration registers.
  logic       square_graph;
  logic [7:0] nonsquare_top_margin;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_graph         <= 1'b1;
      nonsquare_top_margin <= 8'd0;
    end else if (cfg_we && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_ASPECT) begin
        square_graph <= pwdata[0];
      end else begin
        nonsquare_top_margin <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_ASPECT) begin
      prdata[0] = square_graph;
    end else begin
      prdata[7:0] = nonsquare_top_margin;
    end
  end

  // Sequencer state and line registers.
  state_t state, state_next;
  logic [8:0]  x0, x1, cx;
  logic [7:0]  y0, y1, cy;
  logic        setp;
  logic        ysweep;
  logic        endpt;
  logic [11:0] clr_addr;
  logic [11:0] rd_addr;
  logic        rd_valid;

  // Serial divider: |num| / |den|, 17 quotient bits.
  logic [16:0] dnum;
  logic [9:0]  dden;
  logic [9:0]  drem;
  logic [4:0]  dcnt;
  logic        dneg;
  logic [10:0] dtrial;

  // Pixel to write.
  logic [15:0] px;
  logic [7:0]  py;
  logic [11:0] pix_addr;
  logic [4:0]  pix_bit;
  logic        pix_ok;

  // Line deltas.
  logic signed [9:0]  dxs, dys;
  logic signed [9:0]  stepx_off, stepy_off;
  logic signed [17:0] prod;
  logic [17:0]        prod_abs;
  logic [9:0]         den_abs;

  assign dxs = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dys = $signed({2'b00, y1}) - $signed({2'b00, y0});
  assign stepx_off = $signed({1'b0, cx}) - $signed({1'b0, x0});
  assign stepy_off = $signed({2'b00, cy}) - $signed({2'b00, y0});

  // One product per pixel: offset times the other delta (fits 18 bits).
  always_comb begin
    if (!ysweep) begin
      prod    = 18'(stepx_off) * 18'(dys);
      den_abs = dxs[9] ? 10'(-dxs) : 10'(dxs);
    end else begin
      prod    = 18'(stepy_off) * 18'(dxs);
      den_abs = dys[9] ? 10'(-dys) : 10'(dys);
    end
    prod_abs = prod[17] ? 18'(-prod) : 18'(prod);
  end

  assign dtrial = {drem, dnum[16]} - {1'b0, dden};

  // Quotient with sign, then the placed coordinate.
  logic [16:0] quo;
  logic [16:0] quo_s;
  assign quo   = dnum;
  assign quo_s = dneg ? 17'(-quo) : quo;

  // Clip check and address of the current pixel.
  logic [8:0] top_bound;
  assign top_bound = 9'd1 + (square_graph ? 9'd0 : {1'b0, nonsquare_top_margin});
  assign pix_ok = (px > 16'd0) && (px < 16'(GRAPH_WIDTH)) &&
                  ({1'b0, py} > top_bound) && (py < 8'(GRAPH_HEIGHT - 1) + 8'd1
                  || GRAPH_HEIGHT == 256) && ({8'd0, px[15:5]} < 19'(WORDS_PER_ROW));
  assign pix_addr = 12'({4'd0, py} * 12'(WORDS_PER_ROW) + {1'b0, px[15:5]});
  assign pix_bit  = px[4:0];

  // Frame memory.
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [31:0]         ram_wdata, ram_rdata;

  flp_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Has the current sweep finished with its pixels?
  logic xs_done, ys_done;
  logic x_end, y_end;
  assign xs_done = (cx == x1);
  assign ys_done = (cy == y1);
  assign x_end   = !ysweep && (dxs == 10'sd0 || xs_done);
  assign y_end   = ysweep && (dys == 10'sd0 || ys_done);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (action == ACT_READ) ? ST_RDCMD : ST_XDIV;
        end
      end
      ST_CLEAR:  state_next = (clr_addr == 12'(STORE_DEPTH - 1)) ? ST_IDLE : ST_CLEAR;
      ST_XDIV, ST_YDIV: begin
        if (dcnt == 5'd0) begin
          if (x_end) begin
            if (dys == 10'sd0) begin
              state_next = endpt ? ST_IDLE : ST_PIX;
            end
          end else if (y_end) begin
            state_next = (dys == 10'sd0 && !endpt) ? ST_PIX : ST_IDLE;
          end
        end else if (dcnt == 5'd18) begin
          state_next = ST_PIX;
        end
      end
      ST_PIX:    state_next = ST_RD;
      ST_RD:     state_next = ST_WR;
      ST_WR:     state_next = ysweep ? ST_YDIV : ST_XDIV;
      ST_RDCMD:  state_next = ST_RDOUT;
      ST_RDOUT:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = ram_rdata;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = 32'd0;
      end
      ST_RDCMD: ram_addr = rd_addr;
      ST_WR: begin
        ram_we = pix_ok;
        if (setp) begin
          ram_wdata = ram_rdata | (32'd1 << pix_bit);
        end else begin
          ram_wdata = ram_rdata & ~(32'd1 << pix_bit);
        end
      end
      default: ;
    endcase
  end

  // Datapath and sweep control. Plotting sequence per pixel:
  // divide and latch pixel (XDIV/YDIV) -> memory read (PIX, RD) -> write (WR).
  // The end point of a horizontal line skips the division.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= 12'd0;
      done     <= 1'b0;
      was_read <= 1'b0;
      read_data <= 32'd0;
      dcnt     <= 5'd0;
      ysweep   <= 1'b0;
      endpt    <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x0 <= start_x; x1 <= end_x; y0 <= start_y; y1 <= end_y;
            cx <= start_x; cy <= start_y;
            setp    <= set_pixels;
            rd_addr <= read_address;
            rd_valid <= (read_address < 12'(STORE_DEPTH));
            ysweep  <= 1'b0;
            endpt   <= 1'b0;
            dcnt    <= 5'd0;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 12'd1;
        end
        ST_XDIV, ST_YDIV: begin
          if (dcnt == 5'd0) begin
            // Choose the sweep and check for its end before dividing.
            if (x_end) begin
              ysweep <= 1'b1;
              if (dys == 10'sd0) begin
                if (endpt) begin
                  done  <= 1'b1;
                  was_read  <= 1'b0;
                  read_data <= 32'd0;
                end else begin
                  endpt <= 1'b1;
                  px <= {7'd0, x1};
                  py <= y1;
                end
              end
            end else if (y_end) begin
              if (dys == 10'sd0 && !endpt) begin
                endpt <= 1'b1;
                px <= {7'd0, x1};
                py <= y1;
              end else begin
                done  <= 1'b1;
                was_read  <= 1'b0;
                read_data <= 32'd0;
              end
            end else begin
              dnum <= prod_abs[16:0];
              dden <= den_abs;
              drem <= 10'd0;
              dneg <= prod[17] ^ (ysweep ? dys[9] : dxs[9]);
              dcnt <= 5'd1;
            end
          end else if (dcnt == 5'd18) begin
            dcnt <= 5'd0;
            if (!ysweep) begin
              px <= {7'd0, cx};
              py <= 8'(y0 + quo_s[7:0]);
              cx <= dxs[9] ? cx - 9'd1 : cx + 9'd1;
            end else begin
              px <= 16'({7'd0, x0} + quo_s[15:0]);
              py <= cy;
              cy <= dys[9] ? cy - 8'd1 : cy + 8'd1;
            end
          end else begin
            if (!dtrial[10]) begin
              drem <= dtrial[9:0];
              dnum <= {dnum[15:0], 1'b1};
            end else begin
              drem <= {drem[8:0], dnum[16]};
              dnum <= {dnum[15:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
          end
        end
        ST_RDOUT: begin
          done      <= 1'b1;
          was_read  <= 1'b1;
          read_data <= rd_valid ? ram_rdata : 32'd0;
        end
        default: ;
      endcase
    end
  end

  // A result is only given when returning to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE) else $error("result outside idle");
  a_clear_no_req: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> busy) else $error("request possible during clear");
  a_rd_after_cmd: assert property (@(posedge clk) disable iff (rst)
    state == ST_RDOUT |-> $past(state) == ST_RDCMD) else $error("read order");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR |-> $past(state) == ST_RD) else $error("rmw order");
endmodule
`default_nettype wire
